FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define HFCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low
`define HFCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/hfcp_pkg.sv
// ----------------------------------------------------------------------------
// hfcp_pkg
// Types, codes and character helpers for the hex frame checksum parser.
// ----------------------------------------------------------------------------
package hfcp_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 8'd1;

	localparam logic [7:0] START_CODE_RST = 8'h02;
	localparam logic [7:0] END_CODE_RST   = 8'h03;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_UNEXP_END = 2'd2;

	// Parse phases
	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_STN_HI = 3'd1;
	localparam logic [2:0] PH_STN_LO = 3'd2;
	localparam logic [2:0] PH_CMD_HI = 3'd3;
	localparam logic [2:0] PH_CMD_LO = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;

	// ASCII characters
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_F  = 8'h46;
	localparam logic [7:0] TEN   = 8'h0A;
	localparam logic [7:0] NUL   = 8'h00;

	localparam logic [15:0] LEN_MAX       = 16'hFFFF;
	localparam logic [15:0] MIN_FRAME_LEN = 16'd6;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  station;
		logic [7:0]  command;
		logic [7:0]  received_sum;
		logic [7:0]  computed_sum;
		logic [15:0] frame_length;
	} res_t;

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_A) begin
			v = c - CH_A + TEN;
		end else begin
			v = c - CH_0;
		end
		return v[3:0];
	endfunction

endpackage

FILE: sv/hfcp_cfg_regs.sv
// ----------------------------------------------------------------------------
// hfcp_cfg_regs
// Start and end code registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module hfcp_cfg_regs
	import hfcp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 cfg_ready,
	output logic [7:0]           start_code_q,
	output logic [7:0]           end_code_q
);

	// Writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= START_CODE_RST;
			end_code_q   <= END_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START_CODE: start_code_q <= cfg_data;
				CFG_END_CODE:   end_code_q   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/hfcp_frame_core.sv
// ----------------------------------------------------------------------------
// hfcp_frame_core
// Per-byte frame state: phase, running sum, header and checksum characters,
// byte count and decision. Produces the result for the byte flagged as last.
// ----------------------------------------------------------------------------
module hfcp_frame_core
	import hfcp_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data,
	input  logic       last,
	input  logic [7:0] start_code,
	input  logic [7:0] end_code,
	output res_t       result
);

	logic [2:0]             phase_q;
	logic [7:0]             sum_q;
	logic [7:0]             prev_q;
	logic [7:0]             older_q;
	logic [7:0]             station_q;
	logic [7:0]             command_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic [1:0]             status_q;
	logic                   decided_q;
	logic [7:0]             cksum_q;

	logic [2:0]             n_phase;
	logic [7:0]             n_sum;
	logic [7:0]             n_prev;
	logic [7:0]             n_older;
	logic [7:0]             n_station;
	logic [7:0]             n_command;
	logic [LENGTH_BITS-1:0] n_count;
	logic [1:0]             n_status;
	logic                   n_decided;
	logic [7:0]             n_cksum;
	logic                   counts;
	logic [1:0]             fin_status;
	logic [31:0]            count_wide;

	// Next state for one byte
	always_comb begin
		n_phase   = phase_q;
		n_sum     = sum_q;
		n_prev    = prev_q;
		n_older   = older_q;
		n_station = station_q;
		n_command = command_q;
		n_status  = status_q;
		n_decided = decided_q;
		n_cksum   = cksum_q;
		counts    = !decided_q || (status_q == ST_MALFORMED);

		if (!decided_q) begin
			unique case (phase_q)
				PH_START: begin
					if (data != start_code) begin
						n_status  = ST_MALFORMED;
						n_decided = 1'b1;
					end else begin
						n_sum   = data;
						n_phase = PH_STN_HI;
					end
				end
				PH_STN_HI, PH_STN_LO, PH_CMD_HI, PH_CMD_LO: begin
					if (!is_hex(data)) begin
						n_status  = ST_MALFORMED;
						n_decided = 1'b1;
					end else begin
						// Second character of a pair completes the value
						if (phase_q == PH_STN_LO) begin
							n_station = {nibble_of(prev_q), nibble_of(data)};
							n_sum     = sum_q + prev_q + data;
						end else if (phase_q == PH_CMD_LO) begin
							n_command = {nibble_of(prev_q), nibble_of(data)};
							n_sum     = sum_q + prev_q + data;
						end
						n_older = prev_q;
						n_prev  = data;
						n_phase = phase_q + 3'd1;
					end
				end
				PH_DATA: begin
					if (data == end_code) begin
						if (is_hex(older_q) && is_hex(prev_q)) begin
							// Checksum characters come back out of the sum
							n_cksum  = {nibble_of(older_q), nibble_of(prev_q)};
							n_sum    = sum_q - older_q - prev_q;
							n_status = ST_OK;
						end else begin
							n_status = ST_MALFORMED;
						end
						n_decided = 1'b1;
					end else if (data == NUL) begin
						counts    = 1'b0;
						n_status  = ST_UNEXP_END;
						n_decided = 1'b1;
					end else begin
						n_sum   = sum_q + data;
						n_older = prev_q;
						n_prev  = data;
					end
				end
				default: begin
					n_status  = ST_MALFORMED;
					n_decided = 1'b1;
				end
			endcase
		end

		// Saturating byte count
		if (counts && (count_q != {LENGTH_BITS{1'b1}})) begin
			n_count = count_q + 1'b1;
		end else begin
			n_count = count_q;
		end
	end

	// Result for the last byte of a buffer
	always_comb begin
		if (n_decided) begin
			fin_status = n_status;
		end else if (n_phase >= PH_DATA) begin
			fin_status = ST_UNEXP_END;
		end else begin
			fin_status = ST_MALFORMED;
		end
		count_wide          = 32'(n_count);
		result.status       = fin_status;
		result.station      = n_station;
		result.command      = n_command;
		result.received_sum = (fin_status == ST_OK) ? n_cksum : 8'h00;
		result.computed_sum = n_sum;
		result.frame_length = (count_wide > 32'(LEN_MAX)) ? LEN_MAX : count_wide[15:0];
	end

	// State update; the last byte clears the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			sum_q     <= '0;
			prev_q    <= '0;
			older_q   <= '0;
			station_q <= '0;
			command_q <= '0;
			count_q   <= '0;
			status_q  <= ST_OK;
			decided_q <= 1'b0;
			cksum_q   <= '0;
		end else if (step) begin
			if (last) begin
				phase_q   <= PH_START;
				sum_q     <= '0;
				prev_q    <= '0;
				older_q   <= '0;
				station_q <= '0;
				command_q <= '0;
				count_q   <= '0;
				status_q  <= ST_OK;
				decided_q <= 1'b0;
				cksum_q   <= '0;
			end else begin
				phase_q   <= n_phase;
				sum_q     <= n_sum;
				prev_q    <= n_prev;
				older_q   <= n_older;
				station_q <= n_station;
				command_q <= n_command;
				count_q   <= n_count;
				status_q  <= n_status;
				decided_q <= n_decided;
				cksum_q   <= n_cksum;
			end
		end
	end

endmodule

FILE: sv/hex_frame_checksum_parser.sv
// ----------------------------------------------------------------------------
// hex_frame_checksum_parser
// Parses an ASCII hex frame (start code, station, command, data, checksum,
// end code) one byte per transaction and reports one result per buffer.
// ----------------------------------------------------------------------------
// Path: a byte passes through the input register, then the result register.
// Throughput: one byte per cycle while in_stall is low; the frame state updates once per byte.
// A last byte waits in the input register only while an earlier result is stalled.
// Reset: arst_n clears all frame state and the handshakes, start code to 0x02, end to 0x03.
module hex_frame_checksum_parser
	import hfcp_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [7:0]           station,
	output logic [7:0]           command,
	output logic [7:0]           received_sum,
	output logic [7:0]           computed_sum,
	output logic [15:0]          frame_length
);

	logic [7:0] start_code;
	logic [7:0] end_code;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       step;
	logic       out_valid_q;
	res_t       result;
	res_t       result_q;

	hfcp_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg_ready    (cfg_ready),
		.start_code_q (start_code),
		.end_code_q   (end_code)
	);

	// A byte moves on unless it ends a buffer and the result slot stays full
	assign step     = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	hfcp_frame_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data       (byte_s1),
		.last       (last_s1),
		.start_code (start_code),
		.end_code   (end_code),
		.result     (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = result_q.status;
	assign station      = result_q.station;
	assign command      = result_q.command;
	assign received_sum = result_q.received_sum;
	assign computed_sum = result_q.computed_sum;
	assign frame_length = result_q.frame_length;

endmodule

FILE: sv/hfcp_checker.sv
// ----------------------------------------------------------------------------
// hfcp_checker
// Port-level checks on the parser results, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfcp_checker
	import hfcp_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0]           cfg_data,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [7:0]           data_byte,
	input logic                 last_byte,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           status,
	input logic [7:0]           station,
	input logic [7:0]           command,
	input logic [7:0]           received_sum,
	input logic [7:0]           computed_sum,
	input logic [15:0]          frame_length
);

	// Only the three defined status codes appear
	`HFCP_ASSERT_NOW(a_status_code, clk, arst_n, out_valid, (status == ST_OK) || (status == ST_MALFORMED) || (status == ST_UNEXP_END), "undefined status code")

	// A received checksum is reported only for a good frame
	`HFCP_ASSERT_NOW(a_rx_sum_zero, clk, arst_n, out_valid && (status != ST_OK), received_sum == 8'h00, "checksum reported on a failed frame")

	// A good frame holds at least start, header and end code
	`HFCP_ASSERT_NOW(a_ok_min_len, clk, arst_n, out_valid && (status == ST_OK), frame_length >= MIN_FRAME_LEN, "good frame shorter than the minimum")

	// A stalled result holds
	`HFCP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(frame_length) && $stable(computed_sum), "stalled result changed")

endmodule

bind hex_frame_checksum_parser hfcp_checker u_hfcp_checker (.*);

FILE: dv/hfcp_tb_pkg.sv
// ----------------------------------------------------------------------------
// hfcp_tb_pkg
// Frame scoreboard for the hex frame checksum parser: keeps its own copy of
// the parse state and codes, predicts one result per buffer, checks results.
// ----------------------------------------------------------------------------
package hfcp_tb_pkg;
	import hfcp_pkg::*;

	class frame_scoreboard;
		// Configured codes
		logic [7:0]  start_code;
		logic [7:0]  end_code;

		// Parse state of the buffer in progress
		logic [2:0]  phase;
		logic [7:0]  run_sum;
		logic [7:0]  prev_ch;
		logic [7:0]  older_ch;
		logic [7:0]  station;
		logic [7:0]  command;
		logic [15:0] count;
		logic [1:0]  verdict;
		logic        decided;
		logic [7:0]  rx_sum;

		// Results predicted and not yet seen, oldest first
		res_t        frames_due[$];
		int          errors;

		function new();
			start_code = START_CODE_RST;
			end_code   = END_CODE_RST;
			errors     = 0;
			restart();
		endfunction

		function void restart();
			phase    = PH_START;
			run_sum  = 8'h00;
			prev_ch  = 8'h00;
			older_ch = 8'h00;
			station  = 8'h00;
			command  = 8'h00;
			count    = 16'h0000;
			verdict  = ST_OK;
			decided  = 1'b0;
			rx_sum   = 8'h00;
		endfunction

		function void set_code(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
			if (idx == CFG_START_CODE) begin
				start_code = val;
			end else if (idx == CFG_END_CODE) begin
				end_code = val;
			end
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		function logic is_hex_digit(input logic [7:0] c);
			return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
		endfunction

		function logic [3:0] digit_value(input logic [7:0] c);
			logic [7:0] t;
			t = (c >= CH_A) ? (c - CH_A + TEN) : (c - CH_0);
			return t[3:0];
		endfunction

		function void settle(input logic [1:0] st);
			verdict = st;
			decided = 1'b1;
		endfunction

		// Advance the parse by one accepted byte; a last byte yields a result
		function void note_byte(input logic [7:0] c, input logic fin);
			logic       counts;
			logic [7:0] pair;
			res_t       r;
			counts = !decided || (verdict == ST_MALFORMED);
			if (!decided) begin
				if (phase == PH_START) begin
					if (c != start_code) begin
						settle(ST_MALFORMED);
					end else begin
						run_sum = c;
						phase   = PH_STN_HI;
					end
				end else if (phase != PH_DATA) begin
					// header characters, summed a pair at a time
					if (!is_hex_digit(c)) begin
						settle(ST_MALFORMED);
					end else begin
						if (phase == PH_STN_LO || phase == PH_CMD_LO) begin
							pair = {digit_value(prev_ch), digit_value(c)};
							if (phase == PH_STN_LO) begin
								station = pair;
							end else begin
								command = pair;
							end
							run_sum = run_sum + prev_ch + c;
						end
						older_ch = prev_ch;
						prev_ch  = c;
						phase    = phase + 3'd1;
					end
				end else begin
					// data; end code checked before the zero byte
					if (c == end_code) begin
						if (is_hex_digit(older_ch) && is_hex_digit(prev_ch)) begin
							rx_sum  = {digit_value(older_ch), digit_value(prev_ch)};
							run_sum = run_sum - older_ch - prev_ch;
							settle(ST_OK);
						end else begin
							settle(ST_MALFORMED);
						end
					end else if (c == NUL) begin
						counts = 1'b0;
						settle(ST_UNEXP_END);
					end else begin
						run_sum  = run_sum + c;
						older_ch = prev_ch;
						prev_ch  = c;
					end
				end
			end

			if (counts && count != LEN_MAX) begin
				count = count + 16'd1;
			end

			if (fin) begin
				if (!decided) begin
					settle((phase == PH_DATA) ? ST_UNEXP_END : ST_MALFORMED);
				end
				r.status       = verdict;
				r.station      = station;
				r.command      = command;
				r.received_sum = (verdict == ST_OK) ? rx_sum : 8'h00;
				r.computed_sum = run_sum;
				r.frame_length = count;
				frames_due.push_back(r);
				restart();
			end
		endfunction

		function void compare(input string name, input logic [15:0] want,
				input logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
					$time, name, want, got);
				errors++;
			end
		endfunction

		// Check one accepted result against the oldest prediction
		function void check_result(input res_t got);
			res_t want;
			if (frames_due.size() == 0) begin
				$display("%0t: result with none expected: expected nothing, actual %p",
					$time, got);
				errors++;
				return;
			end
			want = frames_due.pop_front();
			compare("status", 16'(want.status), 16'(got.status));
			compare("station", 16'(want.station), 16'(got.station));
			compare("command", 16'(want.command), 16'(got.command));
			compare("received_sum", 16'(want.received_sum), 16'(got.received_sum));
			compare("computed_sum", 16'(want.computed_sum), 16'(got.computed_sum));
			compare("frame_length", want.frame_length, got.frame_length);
		endfunction
	endclass

endpackage

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives buffers of bytes into the hex frame checksum parser under several
// start and end codes: directed frames for each error path, a long malformed
// buffer, then mostly well-formed random frames with some mangled.
// ----------------------------------------------------------------------------
module tb_top;
	import hfcp_pkg::*;
	import hfcp_tb_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 50000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 110;
	localparam int LONG_BYTES   = 40;
	localparam int NUM_SETTINGS = 6;

	typedef enum int {MUT_BYTE, MUT_TRUNC, MUT_NOISE, MUT_ZERO, MUT_CSUM} mutation_e;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [7:0]           cfg_data     = 8'h00;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte    = 8'h00;
	logic                 last_byte    = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [1:0]           status;
	logic [7:0]           station;
	logic [7:0]           command;
	logic [7:0]           received_sum;
	logic [7:0]           computed_sum;
	logic [15:0]          frame_length;

	frame_scoreboard sb;
	logic [7:0]      pend_q[$];
	logic [7:0]      cur_start = START_CODE_RST;
	logic [7:0]      cur_end   = END_CODE_RST;
	logic            quiet     = 1'b0;
	int              hold_cnt  = 0;
	int              cycle_cnt = 0;

	logic [7:0] start_set [NUM_SETTINGS] = '{8'h02, 8'h00, 8'hFF, 8'h41, 8'h00, 8'h3A};
	logic [7:0] end_set   [NUM_SETTINGS] = '{8'h03, 8'hFF, 8'h00, 8'h46, 8'h00, 8'h0D};

	hex_frame_checksum_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.station      (station),
		.command      (command),
		.received_sum (received_sum),
		.computed_sum (computed_sum),
		.frame_length (frame_length)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Receiver stalls in random bursts
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt = hold_cnt - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			hold_cnt = $urandom_range(1, 4);
		end
		out_stall <= (hold_cnt != 0);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			sb.check_result({status, station, command, received_sum, computed_sum,
				frame_length});
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (CH_0 + {4'h0, n}) : (CH_A + {4'h0, n} - TEN);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			pend_q.push_back(s[i]);
		end
	endfunction

	function automatic void add_hex();
		pend_q.push_back(hex_char(4'($urandom_range(0, 15))));
	endfunction

	// Append the correct checksum of everything queued so far
	function automatic void add_sum();
		logic [7:0] s;
		s = 8'h00;
		foreach (pend_q[i]) begin
			s = s + pend_q[i];
		end
		pend_q.push_back(hex_char(s[7:4]));
		pend_q.push_back(hex_char(s[3:0]));
	endfunction

	// One input transaction, with an optional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_byte(b, fin);
	endtask

	// Send the queued buffer, last flag on its final byte
	task automatic send_pending();
		for (int i = 0; i < pend_q.size(); i++) begin
			send_byte(pend_q[i], i == pend_q.size() - 1);
		end
		pend_q.delete();
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.set_code(idx, val);
		if (idx == CFG_START_CODE) begin
			cur_start = val;
		end else begin
			cur_end = val;
		end
		@(posedge clk);
	endtask

	// Stop sending and let every outstanding result drain
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random frames: mostly well formed, about a third mangled
	task automatic run_random(input int budget);
		int         sent;
		int         end_idx;
		logic [7:0] b;
		mutation_e  mut;
		sent = 0;
		while (sent < budget) begin
			pend_q.delete();
			pend_q.push_back(cur_start);
			repeat (4) add_hex();
			repeat ($urandom_range(0, 6)) begin
				do b = 8'($urandom_range(1, 255)); while (b == cur_end);
				pend_q.push_back(b);
			end
			if ($urandom_range(0, 3) != 0) begin
				add_sum();
			end else begin
				add_hex();
				add_hex();
			end
			end_idx = pend_q.size();
			pend_q.push_back(cur_end);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) pend_q.push_back(8'($urandom_range(0, 255)));
			end

			if ($urandom_range(0, 99) >= 65) begin
				mut = mutation_e'($urandom_range(0, 4));
				case (mut)
					MUT_BYTE: begin
						pend_q[$urandom_range(0, pend_q.size() - 1)] =
							8'($urandom_range(0, 255));
					end
					MUT_TRUNC: begin
						repeat ($urandom_range(1, pend_q.size() - 1)) void'(pend_q.pop_back());
					end
					MUT_NOISE: begin
						pend_q.delete();
						repeat ($urandom_range(1, 10))
							pend_q.push_back(8'($urandom_range(0, 255)));
					end
					MUT_ZERO: begin
						pend_q[$urandom_range(5, pend_q.size() - 1)] = NUL;
					end
					default: begin
						pend_q[end_idx - $urandom_range(1, 2)] = 8'($urandom_range(0, 255));
					end
				endcase
			end
			sent += pend_q.size();
			send_pending();
		end
	endtask

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Good frame, then extreme header and data values
		pend_q.push_back(cur_start);
		add_text("0103A5");
		add_sum();
		pend_q.push_back(cur_end);
		send_pending();
		pend_q.push_back(cur_start);
		add_text("FF00");
		pend_q.push_back(8'hFF);
		pend_q.push_back(8'h01);
		pend_q.push_back(8'h7F);
		pend_q.push_back(8'h80);
		add_sum();
		pend_q.push_back(cur_end);
		send_pending();

		// Missing start code, bytes after it still counted
		add_text("AB7");
		send_pending();

		// Bad header characters: lowercase, just outside the ranges, zero byte
		pend_q.push_back(cur_start);
		add_text("1g5");
		send_pending();
		pend_q.push_back(cur_start);
		add_text("9:");
		send_pending();
		pend_q.push_back(cur_start);
		add_text("12@");
		send_pending();
		pend_q.push_back(cur_start);
		add_text("123G");
		send_pending();
		pend_q.push_back(cur_start);
		add_text("1");
		pend_q.push_back(NUL);
		send_pending();

		// Buffer ends on the start code and inside the header
		pend_q.push_back(cur_start);
		send_pending();
		pend_q.push_back(cur_start);
		add_text("12");
		send_pending();

		// Non-hex checksum characters
		pend_q.push_back(cur_start);
		add_text("1234xy");
		pend_q.push_back(cur_end);
		send_pending();

		// Zero byte in data, then buffer ending in data
		pend_q.push_back(cur_start);
		add_text("1234A");
		pend_q.push_back(NUL);
		add_text("B");
		send_pending();
		pend_q.push_back(cur_start);
		add_text("1234AB");
		send_pending();

		// Short data: checksum taken from header characters
		pend_q.push_back(cur_start);
		add_text("1234");
		pend_q.push_back(cur_end);
		send_pending();
		pend_q.push_back(cur_start);
		add_text("1234E");
		pend_q.push_back(cur_end);
		send_pending();

		// Bytes after a good decision are ignored
		pend_q.push_back(cur_start);
		add_text("5A0CQ");
		add_sum();
		pend_q.push_back(cur_end);
		add_text("ZZ");
		pend_q.push_back(NUL);
		send_pending();

		// Long malformed buffer sent back to back, every byte counted
		quiet = 1'b1;
		for (int i = 0; i < LONG_BYTES; i++) begin
			send_byte(8'h55, i == LONG_BYTES - 1);
		end
		quiet = 1'b0;

		// End code of zero wins over the zero-byte check
		wait_idle();
		write_cfg(CFG_END_CODE, NUL);
		pend_q.push_back(cur_start);
		add_text("1234A");
		add_sum();
		pend_q.push_back(cur_end);
		send_pending();

		// Random frames under each code setting; the last runs without idling
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			wait_idle();
			if (p == 4) begin
				write_cfg(CFG_START_CODE, 8'($urandom_range(0, 255)));
				write_cfg(CFG_END_CODE, 8'($urandom_range(0, 255)));
			end else begin
				write_cfg(CFG_START_CODE, start_set[p]);
				write_cfg(CFG_END_CODE, end_set[p]);
			end
			if (p == NUM_SETTINGS - 1) begin
				quiet = 1'b1;
			end
			run_random(RANDOM_BYTES);
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/hfcp_pkg.sv
sv/hfcp_cfg_regs.sv
sv/hfcp_frame_core.sv
sv/hex_frame_checksum_parser.sv
sv/hfcp_checker.sv
dv/hfcp_tb_pkg.sv
dv/tb_top.sv
